FILE: src/wost_pkg.sv
// Shared types and constants for the weight-ordered stack table.
// Used by the top, wost_cell and wost_pick; no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package wost_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int ID_W        = 16;
	localparam int WGT_W       = 16;
	localparam int POS_W       = 6;
	localparam int OCC_W       = 7;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_REMOVE = 2'd2,
		OP_POP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	// Per-cell update selection for one cycle
	typedef enum logic [1:0] {
		MV_HOLD  = 2'd0,
		MV_LOAD  = 2'd1,
		MV_BELOW = 2'd2,
		MV_ABOVE = 2'd3
	} move_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [WGT_W-1:0] weight;
	} entry_t;

	typedef struct packed {
		op_t              op;
		logic [ID_W-1:0]  box_id;
		logic [WGT_W-1:0] weight;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [POS_W-1:0] position;
		logic [ID_W-1:0]  found_id;
		logic [WGT_W-1:0] found_weight;
		logic [OCC_W-1:0] occupancy;
	} rsp_t;

endpackage

`default_nettype wire

FILE: src/weight_ordered_stack_table_top.sv
// Weight-ordered stack table: a row of STACK_DEPTH slot cells kept sorted by
// non-increasing weight from the bottom, serving insert, lookup, remove and pop.
// Depends on wost_pkg, wost_cell, wost_locate and wost_pick.
//
// A new request is taken only while the request register is empty; the request
// transfer loads that register. In the next cycle every cell compares its entry
// with the request, a log-depth prefix network finds the lowest id match (the
// sorted weights give the insert point directly), a one-hot encoder turns the
// chosen slot into a position, and once the output register is free all cells
// shift up, shift down or hold together as the result is written to it. req_stall
// is high while the request register holds a request, also while a finished
// result waits in the output register with the next request already held. There
// is no clearing pass after reset: slots above the occupancy are never read.
`timescale 1ns / 1ps
`default_nettype none

module weight_ordered_stack_table_top #(
	parameter int STACK_DEPTH = wost_pkg::STACK_DEPTH
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             req_valid,
	output logic            req_stall,
	input  wost_pkg::req_t  req,
	output logic            rsp_valid,
	input  wire             rsp_stall,
	output wost_pkg::rsp_t  rsp
);

	localparam int IDX_W = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	logic             s1_valid_q;
	wost_pkg::req_t   s1_q;
	logic             rsp_valid_q;
	wost_pkg::rsp_t   rsp_q;
	logic [CNT_W-1:0] count_q;

	wost_pkg::entry_t                     key;
	wost_pkg::entry_t [STACK_DEPTH-1:0]   ents;
	wost_pkg::move_t  [STACK_DEPTH-1:0]   mv;
	logic [STACK_DEPTH-1:0] occ, ge, match, incl, first, boundary, top, sel;
	logic [IDX_W-1:0]       idx;
	wost_pkg::entry_t       picked;
	logic                   adv, full, found, empty;
	logic [CNT_W-1:0]       count_d;
	wost_pkg::rsp_t         res;
	logic [IDX_W+wost_pkg::POS_W-1:0] pos_ext;
	logic [CNT_W+wost_pkg::OCC_W-1:0] occ_ext;

	assign key.id     = s1_q.box_id;
	assign key.weight = s1_q.weight;

	assign req_stall = s1_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign adv       = s1_valid_q && (!rsp_valid_q || !rsp_stall);

	genvar gi;
	generate
		for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
			wost_pkg::entry_t below_in, above_in;

			assign occ[gi] = count_q > CNT_W'(gi);

			if (gi == 0) begin : g_bot
				assign below_in = key;
			end else begin : g_mid_lo
				assign below_in = ents[gi-1];
			end
			if (gi == STACK_DEPTH - 1) begin : g_top
				assign above_in = ents[gi];
			end else begin : g_mid_hi
				assign above_in = ents[gi+1];
			end

			wost_cell u_cell (
				.clk   (clk),
				.occ   (occ[gi]),
				.key   (key),
				.mv    (mv[gi]),
				.below (below_in),
				.above (above_in),
				.ent   (ents[gi]),
				.ge    (ge[gi]),
				.match (match[gi])
			);
		end
	endgenerate

	wost_locate #(.DEPTH(STACK_DEPTH)) u_locate (
		.match (match),
		.incl  (incl),
		.first (first)
	);

	// Sorted order makes ge a run of ones from the bottom; the insert
	// point is the first slot past that run.
	assign boundary = ~ge & {ge[STACK_DEPTH-2:0], 1'b1};
	assign top      = occ & ~{1'b0, occ[STACK_DEPTH-1:1]};

	assign full  = count_q == CNT_W'(STACK_DEPTH);
	assign empty = count_q == '0;
	assign found = incl[STACK_DEPTH-1];

	always_comb begin
		case (s1_q.op)
			wost_pkg::OP_INSERT: sel = boundary;
			wost_pkg::OP_LOOKUP,
			wost_pkg::OP_REMOVE: sel = first;
			default:             sel = top;
		endcase
	end

	wost_pick #(.DEPTH(STACK_DEPTH)) u_pick (
		.sel  (sel),
		.ents (ents),
		.idx  (idx),
		.ent  (picked)
	);

	always_comb begin
		for (int i = 0; i < STACK_DEPTH; i++) begin
			mv[i] = wost_pkg::MV_HOLD;
			if (adv) begin
				case (s1_q.op)
					wost_pkg::OP_INSERT: begin
						if (!full && !ge[i]) begin
							mv[i] = boundary[i] ? wost_pkg::MV_LOAD : wost_pkg::MV_BELOW;
						end
					end
					wost_pkg::OP_REMOVE: begin
						if (incl[i]) begin
							mv[i] = wost_pkg::MV_ABOVE;
						end
					end
					default: mv[i] = wost_pkg::MV_HOLD;
				endcase
			end
		end
	end

	always_comb begin
		count_d          = count_q;
		res.status       = wost_pkg::ST_OK;
		res.found_id     = picked.id;
		res.found_weight = picked.weight;
		case (s1_q.op)
			wost_pkg::OP_INSERT: begin
				res.found_id     = key.id;
				res.found_weight = key.weight;
				if (full) begin
					res.status = wost_pkg::ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			wost_pkg::OP_LOOKUP: begin
				if (!found) begin
					res.status = wost_pkg::ST_NOT_FOUND;
				end
			end
			wost_pkg::OP_REMOVE: begin
				if (!found) begin
					res.status = wost_pkg::ST_NOT_FOUND;
				end else begin
					count_d = count_q - CNT_W'(1);
				end
			end
			default: begin
				if (empty) begin
					res.status = wost_pkg::ST_EMPTY;
				end else begin
					count_d = count_q - CNT_W'(1);
				end
			end
		endcase
		pos_ext      = {{wost_pkg::POS_W{1'b0}}, idx};
		occ_ext      = {{wost_pkg::OCC_W{1'b0}}, count_d};
		res.position = pos_ext[wost_pkg::POS_W-1:0];
		res.occupancy = occ_ext[wost_pkg::OCC_W-1:0];
		// Failed operations report zeros
		if (res.status != wost_pkg::ST_OK) begin
			res.position     = '0;
			res.found_id     = '0;
			res.found_weight = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
			if (adv) begin
				rsp_valid_q <= 1'b1;
				count_q     <= count_d;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			s1_q <= req;
		end
		if (adv) begin
			rsp_q <= res;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("occupancy exceeds stack depth");

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> ((ge & (ge + STACK_DEPTH'(1))) == '0))
		else $error("stored weights out of order");

	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q |-> $onehot0(sel))
		else $error("slot select not one-hot");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && s1_q.op == wost_pkg::OP_INSERT && !full)
		|=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow occupancy");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> rsp_valid_q)
		else $error("finished request produced no result");

endmodule

`default_nettype wire

FILE: src/wost_cell.sv
// One stack slot: holds an entry, compares it against the request key and
// takes a new value from the key or a neighbor. Depends on wost_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wost_cell (
	input  wire                  clk,
	input  wire                  occ,
	input  wost_pkg::entry_t     key,
	input  wost_pkg::move_t      mv,
	input  wost_pkg::entry_t     below,
	input  wost_pkg::entry_t     above,
	output wost_pkg::entry_t     ent,
	output logic                 ge,
	output logic                 match
);

	wost_pkg::entry_t ent_q;

	assign ent   = ent_q;
	assign ge    = occ && (ent_q.weight >= key.weight);
	assign match = occ && (ent_q.id == key.id);

	always_ff @(posedge clk) begin
		case (mv)
			wost_pkg::MV_HOLD:  ent_q <= ent_q;
			wost_pkg::MV_LOAD:  ent_q <= key;
			wost_pkg::MV_BELOW: ent_q <= below;
			wost_pkg::MV_ABOVE: ent_q <= above;
			default:            ent_q <= ent_q;
		endcase
	end

endmodule

`default_nettype wire

FILE: src/wost_locate.sv
// Parallel prefix OR over the per-cell id matches; marks the lowest match.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module wost_locate #(
	parameter int DEPTH = 64
) (
	input  wire  [DEPTH-1:0] match,
	output logic [DEPTH-1:0] incl,
	output logic [DEPTH-1:0] first
);

	localparam int LVL = $clog2(DEPTH);

	logic [DEPTH-1:0] pfx [LVL+1];

	// Log-depth prefix: level l folds in the element 2^l places below
	always_comb begin
		pfx[0] = match;
		for (int l = 0; l < LVL; l++) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (i >= (1 << l)) begin
					pfx[l+1][i] = pfx[l][i] | pfx[l][i-(1<<l)];
				end else begin
					pfx[l+1][i] = pfx[l][i];
				end
			end
		end
	end

	assign incl  = pfx[LVL];
	assign first = match & ~{incl[DEPTH-2:0], 1'b0};

endmodule

`default_nettype wire

FILE: src/wost_pick.sv
// One-hot select to slot index, plus the selected slot's entry.
// Depends on wost_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module wost_pick #(
	parameter int DEPTH = 64
) (
	input  wire  [DEPTH-1:0]               sel,
	input  wost_pkg::entry_t [DEPTH-1:0]   ents,
	output logic [$clog2(DEPTH)-1:0]       idx,
	output wost_pkg::entry_t               ent
);

	localparam int IDX_W = $clog2(DEPTH);

	always_comb begin
		idx = '0;
		ent = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (sel[i]) begin
				idx = idx | IDX_W'(i);
				ent = ent | ents[i];
			end
		end
	end

endmodule

`default_nettype wire
